// ----- hdl/ppfl_pkg.sv -----
// ppfl_pkg: shared constants, codes and control types for the per-cpu page allocator
// used by ppfl_ctrl, ppfl_dpath and per_cpu_page_free_list_allocator_core
package ppfl_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W = 32;
  localparam int CPU_W  = $clog2(NUM_CPUS);
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int OFFS_W = $clog2(PAGE_BYTES);
  localparam int PFN_W  = ADDR_W - OFFS_W;
  localparam int FPG_W  = PFN_W + 1;
  localparam int LINK_W = PAGE_W + 1;
  localparam int STAT_W = 2;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RESET  = 32'h8800_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_TOP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic accept;
    logic link_done;
  } ppfl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_link;
  } ppfl_sts_t;

endpackage

// ----- hdl/ppfl_ctrl.sv -----
// ppfl_ctrl: sequencer for the page allocator, input handshake and link-read wait
// depends on ppfl_pkg
module ppfl_ctrl
  import ppfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ppfl_sts_t sts,
  output ppfl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LINK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = !((state_r == S_IDLE) && sts.out_free);

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.link_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept && sts.need_link) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/ppfl_dpath.sv -----
// ppfl_dpath: config registers, list heads, next-link memory and result register
// depends on ppfl_pkg; sequenced by ppfl_ctrl
module ppfl_dpath
  import ppfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              in_kind,
  input  logic [CPU_W-1:0]  in_cpu,
  input  logic [ADDR_W-1:0] in_page_addr,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_alloc_addr,
  input  ppfl_cmd_t         cmd,
  output ppfl_sts_t         sts
);

  logic [ADDR_W-1:0] base_r, top_r;
  logic [NUM_CPUS-1:0] head_vld_r;
  logic [PAGE_W-1:0] head_pg_r [NUM_CPUS];
  logic [LINK_W-1:0] link_mem [NUM_PAGES];
  logic [LINK_W-1:0] link_rd_r;
  logic [CPU_W-1:0] sel_r;
  logic [PAGE_W-1:0] pg_r;
  logic out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [ADDR_W-1:0] alloc_addr_r;

  logic [FPG_W-1:0] first_pg;
  logic [FPG_W-1:0] idx_full;
  logic [PAGE_W-1:0] idx;
  logic bad_addr;
  logic [CPU_W-1:0] sel;
  logic any_vld;
  logic push;
  logic pop_rd;
  logic [PFN_W-1:0] pop_pfn;

  assign first_pg = {1'b0, base_r[ADDR_W-1:OFFS_W]} + FPG_W'(base_r[OFFS_W-1:0] != '0);
  assign idx_full = {1'b0, in_page_addr[ADDR_W-1:OFFS_W]} - first_pg;
  assign idx      = idx_full[PAGE_W-1:0];
  assign bad_addr = (in_page_addr[OFFS_W-1:0] != '0) || (in_page_addr < base_r) ||
                    (in_page_addr >= top_r) || (idx_full[FPG_W-1:PAGE_W] != '0);

  // own list first, else lowest-numbered other cpu with pages
  always_comb begin
    sel = in_cpu;
    if (!head_vld_r[in_cpu]) begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (head_vld_r[i] && (CPU_W'(i) != in_cpu)) begin
          sel = CPU_W'(i);
        end
      end
    end
  end

  assign any_vld       = |head_vld_r;
  assign sts.need_link = (in_kind == KIND_ALLOC) && any_vld;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign push    = cmd.accept && (in_kind == KIND_FREE) && !bad_addr;
  assign pop_rd  = cmd.accept && sts.need_link;
  assign pop_pfn = first_pg[PFN_W-1:0] + PFN_W'(pg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      top_r  <= TOP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE) begin
        base_r <= cfg_wdata;
      end else begin
        top_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      link_mem[idx] <= {head_vld_r[in_cpu], head_pg_r[in_cpu]};
    end
    if (pop_rd) begin
      link_rd_r <= link_mem[head_pg_r[sel]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (push) begin
      head_vld_r[in_cpu] <= 1'b1;
    end else if (cmd.link_done) begin
      head_vld_r[sel_r] <= link_rd_r[LINK_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head_pg_r[in_cpu] <= idx;
    end else if (cmd.link_done) begin
      head_pg_r[sel_r] <= link_rd_r[PAGE_W-1:0];
    end
    if (pop_rd) begin
      sel_r <= sel;
      pg_r  <= head_pg_r[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && !sts.need_link) || cmd.link_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link_done) begin
      status_r     <= ST_OK;
      alloc_addr_r <= {pop_pfn, OFFS_W'(0)};
    end else if (cmd.accept && !sts.need_link) begin
      alloc_addr_r <= '0;
      if (in_kind == KIND_ALLOC) begin
        status_r <= ST_OOM;
      end else if (bad_addr) begin
        status_r <= ST_BAD;
      end else begin
        status_r <= ST_OK;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_alloc_addr = alloc_addr_r;

  a_link_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link_done |=> out_valid_r)
    else $error("pop finished without a result beat");

  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (in_kind == KIND_FREE) |=> out_valid_r && (status_r != ST_OOM))
    else $error("free item gave no result or an out of memory status");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> alloc_addr_r == '0)
    else $error("failed item carries an address");

  a_no_accept_in_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link_done |-> !cmd.accept)
    else $error("item accepted during link read");

endmodule

// ----- hdl/per_cpu_page_free_list_allocator_core.sv -----
// Per-CPU LIFO page allocator: one free list per cpu linked through a next-link memory,
// a free pushes a checked page onto its cpu's list, an alloc pops its own list or steals
// from the lowest-numbered other cpu. Frees, and allocs that find every list empty, go
// straight to the result register; a popping alloc first visits the link state, as the
// next-link memory read must return before the list head is updated. Results sit in a single
// output register, so a new item is taken only while it is empty or its beat leaves in the
// same cycle; a stalled result holds off the input. Lists reset empty; no clearing pass.
// depends on ppfl_pkg, ppfl_ctrl, ppfl_dpath
module per_cpu_page_free_list_allocator_core
  import ppfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [CPU_W-1:0]  in_cpu,
  input  logic [ADDR_W-1:0] in_page_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_alloc_addr
);

  ppfl_cmd_t cmd;
  ppfl_sts_t sts;

  ppfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppfl_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_cpu         (in_cpu),
    .in_page_addr   (in_page_addr),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_alloc_addr (out_alloc_addr),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- tb/sv/per_cpu_page_free_list_allocator_core_test.sv -----
// per_cpu_page_free_list_allocator_core_test: self-checking bench for the per-cpu page allocator,
// with an in-bench predictor of the free lists, a queue-fed driver, a checking monitor
// depends on ppfl_pkg and per_cpu_page_free_list_allocator_core
module per_cpu_page_free_list_allocator_core_test
  import ppfl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic              kind;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } page_rsp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_BASE;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_ALLOC;
  logic [CPU_W-1:0]  in_cpu = '0;
  logic [ADDR_W-1:0] in_page_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_alloc_addr;

  // predictor state
  logic [ADDR_W-1:0] mdl_base = BASE_RESET;
  logic [ADDR_W-1:0] mdl_top  = TOP_RESET;
  bit                lst_vld  [NUM_CPUS];
  bit [PAGE_W-1:0]   lst_head [NUM_CPUS];
  bit                nxt_vld  [NUM_PAGES];
  bit [PAGE_W-1:0]   nxt_page [NUM_PAGES];

  page_req_t page_reqs[$];
  page_rsp_t page_outcomes[$];
  page_req_t drv_req;
  page_rsp_t mon_exp;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int unsigned fresh_pg = 0;
  int unsigned on_list = 0;

  int n_accepted = 0, n_results = 0, n_errors = 0, n_cfg = 0;
  int n_alloc = 0, n_steal = 0, n_oom = 0, n_free = 0, n_bad = 0;

  per_cpu_page_free_list_allocator_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_cpu         (in_cpu),
    .in_page_addr   (in_page_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_alloc_addr (out_alloc_addr)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned first_page();
    longint unsigned b;
    b = mdl_base;
    if (mdl_base[OFFS_W-1:0] != '0) b = b + PAGE_BYTES - mdl_base[OFFS_W-1:0];
    return b;
  endfunction

  function automatic int unsigned page_window();
    longint unsigned f, top, span;
    f = first_page();
    top = mdl_top;
    if (top <= f) return 0;
    span = (top - f + PAGE_BYTES - 1) / PAGE_BYTES;
    return (span > NUM_PAGES) ? NUM_PAGES : int'(span);
  endfunction

  function automatic bit page_of(input logic [ADDR_W-1:0] a, output int unsigned idx);
    longint unsigned off;
    idx = 0;
    if (a[OFFS_W-1:0] != '0 || a < mdl_base || a >= mdl_top) return 1'b0;
    off = a;
    off = (off - first_page()) / PAGE_BYTES;
    if (off >= NUM_PAGES) return 1'b0;
    idx = int'(off);
    return 1'b1;
  endfunction

  function automatic bit pop_head(input int c, output int unsigned pg);
    pg = 0;
    if (!lst_vld[c]) return 1'b0;
    pg = lst_head[c];
    lst_vld[c] = nxt_vld[pg];
    lst_head[c] = nxt_page[pg];
    return 1'b1;
  endfunction

  function automatic page_rsp_t compute_outcome(input page_req_t r);
    page_rsp_t rsp;
    int unsigned idx, pg;
    bit got;
    int c;
    rsp.status = ST_OK;
    rsp.addr = '0;
    if (r.kind == KIND_FREE) begin
      n_free++;
      if (!page_of(r.addr, idx)) begin
        rsp.status = ST_BAD;
        n_bad++;
      end else begin
        nxt_vld[idx] = lst_vld[r.cpu];
        nxt_page[idx] = lst_head[r.cpu];
        lst_vld[r.cpu] = 1'b1;
        lst_head[r.cpu] = idx[PAGE_W-1:0];
      end
      return rsp;
    end
    n_alloc++;
    got = pop_head(r.cpu, pg);
    for (c = 0; c < NUM_CPUS && !got; c++) begin
      if (c != r.cpu) begin
        got = pop_head(c, pg);
        if (got) n_steal++;
      end
    end
    if (!got) begin
      rsp.status = ST_OOM;
      n_oom++;
    end else begin
      rsp.addr = ADDR_W'(first_page() + longint'(pg) * PAGE_BYTES);
    end
    return rsp;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        page_outcomes.push_back(compute_outcome('{in_kind, in_cpu, in_page_addr}));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (page_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = page_reqs.pop_front();
          in_valid <= 1'b1;
          in_kind <= drv_req.kind;
          in_cpu <= drv_req.cpu;
          in_page_addr <= drv_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (page_outcomes.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected beat: status %0d alloc_addr %h with nothing pending",
                     out_status, out_alloc_addr);
        end else begin
          mon_exp = page_outcomes.pop_front();
          if (out_status !== mon_exp.status || out_alloc_addr !== mon_exp.addr) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch on beat %0d: status exp %0d got %0d, alloc_addr exp %h got %h",
                       n_results, mon_exp.status, out_status, mon_exp.addr, out_alloc_addr);
          end
        end
      end
      out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == CFG_BASE) mdl_base = v;
    else mdl_top = v;
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled mid-cycle so the driver's last beat is already visible
  task automatic wait_idle();
    while (page_reqs.size() != 0 || in_valid || page_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_req(input logic kind, input logic [CPU_W-1:0] c,
                           input logic [ADDR_W-1:0] a);
    int unsigned idx;
    page_reqs.push_back('{kind, c, a});
    if (kind == KIND_FREE) begin
      if (page_of(a, idx)) on_list++;
    end else if (on_list > 0) begin
      on_list--;
    end
  endtask

  // fresh pages only, so no page is ever on two lists at once
  task automatic queue_good_free(input logic [CPU_W-1:0] c);
    if (fresh_pg < page_window()) begin
      queue_req(KIND_FREE, c, ADDR_W'(first_page() + longint'(fresh_pg) * PAGE_BYTES));
      fresh_pg++;
    end else begin
      queue_req(KIND_ALLOC, c, $urandom);
    end
  endtask

  task automatic queue_bad_free(input logic [CPU_W-1:0] c);
    logic [ADDR_W-1:0] a;
    int unsigned idx;
    case ($urandom_range(3))
      0: a = $urandom;
      1: a = mdl_base - PAGE_BYTES * $urandom_range(4, 1);
      2: a = {mdl_top[ADDR_W-1:OFFS_W], {OFFS_W{1'b0}}} + PAGE_BYTES * $urandom_range(3);
      default: a = ADDR_W'(first_page() + longint'(NUM_PAGES + $urandom_range(7)) * PAGE_BYTES);
    endcase
    if (page_of(a, idx)) a[$urandom_range(OFFS_W-1)] = 1'b1;
    queue_req(KIND_FREE, c, a);
  endtask

  // bursts that fill, drain or mix, good frees aimed at a random subset of cpus
  task automatic run_mix(input int n);
    int left, len, mode, r, free_cut, alloc_cut;
    logic [NUM_CPUS-1:0] mask;
    logic [CPU_W-1:0] c;
    left = n;
    while (left > 0) begin
      len = $urandom_range(40, 8);
      if (len > left) len = left;
      left -= len;
      mode = $urandom_range(2);
      mask = NUM_CPUS'($urandom);
      if (mask == '0) mask[0] = 1'b1;
      free_cut = (mode == 0) ? 75 : (mode == 1) ? 15 : 45;
      alloc_cut = (mode == 0) ? 90 : (mode == 1) ? 95 : 90;
      repeat (len) begin
        r = $urandom_range(99);
        c = CPU_W'($urandom_range(NUM_CPUS-1));
        if (r < free_cut) begin
          while (!mask[c]) c = CPU_W'($urandom_range(NUM_CPUS-1));
          queue_good_free(c);
        end else if (r < alloc_cut) begin
          queue_req(KIND_ALLOC, c, $urandom);
        end else begin
          queue_bad_free(c);
        end
      end
    end
  endtask

  task automatic drain_lists();
    wait_idle();
    repeat (on_list) queue_req(KIND_ALLOC, CPU_W'($urandom_range(NUM_CPUS-1)), $urandom);
    wait_idle();
    fresh_pg = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty lists, range edges, lifo order, stealing
    queue_req(KIND_ALLOC, 0, '0);
    queue_req(KIND_FREE, 0, BASE_RESET);
    queue_req(KIND_FREE, 7, TOP_RESET - PAGE_BYTES);
    queue_req(KIND_FREE, 1, TOP_RESET);
    queue_req(KIND_FREE, 2, BASE_RESET - PAGE_BYTES);
    queue_req(KIND_FREE, 3, BASE_RESET + 1);
    queue_req(KIND_FREE, 4, 32'hFFFF_FFFF);
    queue_req(KIND_FREE, 5, '0);
    queue_req(KIND_ALLOC, 7, 32'hFFFF_FFFF);
    queue_req(KIND_ALLOC, 3, '0);
    queue_req(KIND_ALLOC, 5, '0);
    queue_req(KIND_FREE, 2, BASE_RESET + 5 * PAGE_BYTES);
    queue_req(KIND_FREE, 2, BASE_RESET + 6 * PAGE_BYTES);
    queue_req(KIND_FREE, 6, BASE_RESET + 7 * PAGE_BYTES);
    queue_req(KIND_ALLOC, 2, '0);
    queue_req(KIND_ALLOC, 0, '0);
    queue_req(KIND_ALLOC, 0, '0);
    queue_req(KIND_ALLOC, 4, '0);
    wait_idle();
    fresh_pg = 8;
    run_mix(430);

    // widest range, sender gaps, one pause midway until every pending item is answered
    drain_lists();
    write_reg(CFG_BASE, '0);
    write_reg(CFG_TOP, 32'hFFFF_FFFF);
    send_idle_pct = 80;
    run_mix(220);
    wait_idle();
    run_mix(220);

    // unaligned base, changed while pages still sit on the lists
    wait_idle();
    write_reg(CFG_BASE, 32'h0010_0800);
    write_reg(CFG_TOP, 32'h0100_0000);
    send_idle_pct = 0;
    stall_pct = 80;
    run_mix(440);

    // degenerate ranges: nothing can be freed, then a single page
    drain_lists();
    write_reg(CFG_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_TOP, '0);
    send_idle_pct = 38;
    stall_pct = 38;
    run_mix(20);
    drain_lists();
    write_reg(CFG_BASE, 32'hFFFF_F000);
    write_reg(CFG_TOP, 32'hFFFF_FFFF);
    run_mix(40);

    // small range with a long receiver hold-off so the input backs up
    drain_lists();
    write_reg(CFG_BASE, 32'h4000_0000);
    write_reg(CFG_TOP, 32'h4004_0000);
    run_mix(500);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    run_mix(60);

    // double free: the page comes back on every pop
    drain_lists();
    queue_req(KIND_FREE, 1, 32'h4000_3000);
    queue_req(KIND_FREE, 1, 32'h4000_3000);
    queue_req(KIND_ALLOC, 1, '0);
    queue_req(KIND_ALLOC, 1, '0);
    queue_req(KIND_ALLOC, 6, '0);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d items: %0d allocs (%0d taken from another cpu, %0d out of memory),",
             n_accepted, n_alloc, n_steal, n_oom);
    $display("  %0d frees (%0d rejected), %0d register writes, %0d results, %0d mismatches",
             n_free, n_bad, n_cfg, n_results, n_errors);
    if (n_errors == 0 && page_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ppfl_pkg.sv
hdl/ppfl_ctrl.sv
hdl/ppfl_dpath.sv
hdl/per_cpu_page_free_list_allocator_core.sv
tb/sv/per_cpu_page_free_list_allocator_core_test.sv
